// ===== rtl/bc_pkg.sv =====
// Package: widths, word types, status codes and sequencer states for the binomial block.
`default_nettype none
package bc_pkg;

  localparam int RESULT_WIDTH = 64;
  localparam int COEF_W       = 64;
  localparam int CNT_W        = 6;
  localparam int PROD_W       = RESULT_WIDTH + CNT_W;
  localparam int DIV_CNT_W    = $clog2(RESULT_WIDTH + 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ORDER    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] choose_count;
  } bc_in_t;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic [1:0]        status;
  } bc_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NUM,
    S_DEN,
    S_DIV
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bc_div
  import bc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [RESULT_WIDTH-1:0] dividend,
  input  wire logic [RESULT_WIDTH-1:0] divisor,
  output logic                         done,
  output logic [RESULT_WIDTH-1:0]      quotient
);

  logic [RESULT_WIDTH-1:0] rem;
  logic [RESULT_WIDTH-1:0] dvsr;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [RESULT_WIDTH:0]   shifted;
  logic [RESULT_WIDTH:0]   diff;

  assign shifted = {rem, quotient[RESULT_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(RESULT_WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (cnt != '0) begin
      if (!diff[RESULT_WIDTH]) begin
        rem      <= diff[RESULT_WIDTH-1:0];
        quotient <= {quotient[RESULT_WIDTH-2:0], 1'b1};
      end else begin
        rem      <= shifted[RESULT_WIDTH-1:0];
        quotient <= {quotient[RESULT_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/binomial_coefficient.sv =====
// Top level: binomial coefficient C(m, n) by the multiplicative form.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+------------------------------
//  input    | operands                  | start, taken when busy is low
//  result   | result                    | done, one-cycle strobe
//
// Each word runs the numerator steps and then the denominator steps, with
// k = min(n, m - n) of each, on one shared multiplier; the quotient then
// comes from the restoring divider.
// n > m or numerator overflow ends the word early. Reset clears the
// sequencer; busy stays high until done. The receiver cannot stall.
`default_nettype none
module binomial_coefficient
  import bc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire bc_in_t  operands,
  output logic         busy,
  output logic         done,
  output bc_out_t      result
);

  state_t                  state, state_next;
  logic [CNT_W-1:0]        m, m_next;
  logic [CNT_W-1:0]        k, k_next;
  logic [CNT_W-1:0]        i, i_next;
  logic [RESULT_WIDTH-1:0] num, num_next;
  logic [RESULT_WIDTH-1:0] den, den_next;
  logic                    done_next;
  bc_out_t                 result_next;

  logic [RESULT_WIDTH-1:0] mul_a;
  logic [CNT_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod;
  logic [CNT_W-1:0]        diff_mn;

  logic                    div_start;
  logic                    div_done;
  logic [RESULT_WIDTH-1:0] quotient;

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign diff_mn = operands.total_count - operands.choose_count;
  assign busy    = (state != S_IDLE);

  bc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    m      <= m_next;
    k      <= k_next;
    i      <= i_next;
    num    <= num_next;
    den    <= den_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    m_next      = m;
    k_next      = k;
    i_next      = i;
    num_next    = num;
    den_next    = den;
    done_next   = 1'b0;
    result_next = result;
    div_start   = 1'b0;
    mul_a       = num;
    mul_b       = m - i;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operands.choose_count > operands.total_count) begin
            done_next   = 1'b1;
            result_next = '{coefficient: '0, status: STATUS_ORDER};
          end else begin
            m_next     = operands.total_count;
            k_next     = (operands.choose_count <= diff_mn) ? operands.choose_count
                                                            : diff_mn;
            i_next     = '0;
            num_next   = RESULT_WIDTH'(1);
            state_next = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (i == k) begin
          i_next     = '0;
          den_next   = RESULT_WIDTH'(1);
          state_next = S_DEN;
        end else if (prod[PROD_W-1:RESULT_WIDTH] != '0) begin
          done_next   = 1'b1;
          result_next = '{coefficient: '0, status: STATUS_OVERFLOW};
          state_next  = S_IDLE;
        end else begin
          num_next = prod[RESULT_WIDTH-1:0];
          i_next   = i + 1'b1;
        end
      end
      S_DEN: begin
        mul_a = den;
        mul_b = i + 1'b1;
        if (i == k) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          den_next = prod[RESULT_WIDTH-1:0];
          i_next   = i + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          done_next   = 1'b1;
          result_next = '{coefficient: COEF_W'(quotient), status: STATUS_OK};
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
